// ===== hw/rtl/mtep_pkg.sv =====
// Shared types and constants for the MIDI track event parser.
// Holds the parse phase enum, the parser state, item and result structs.
// No dependencies.
package mtep_pkg;

	// Status and meta codes
	localparam logic [7:0]  STATUS_META   = 8'hFF;
	localparam logic [7:0]  STATUS_SYSEX  = 8'hF0;
	localparam logic [7:0]  STATUS_ESCAPE = 8'hF7;
	localparam logic [7:0]  META_EOT      = 8'h2F;
	localparam logic [7:0]  META_TEMPO    = 8'h51;
	localparam logic [3:0]  KIND_SYSTEM   = 4'hF;
	localparam logic [3:0]  KIND_NOTE_ON  = 4'h9;
	localparam logic [3:0]  KIND_PROGRAM  = 4'hC;
	localparam logic [3:0]  KIND_PRESSURE = 4'hD;
	localparam logic [23:0] TEMPO_RESET   = 24'd500000;

	// Error kinds
	localparam logic [2:0] ERR_NONE        = 3'd0;
	localparam logic [2:0] ERR_VARLEN      = 3'd1;
	localparam logic [2:0] ERR_NO_STATUS   = 3'd2;
	localparam logic [2:0] ERR_TRUNCATED   = 3'd3;
	localparam logic [2:0] ERR_UNSUPPORTED = 3'd4;

	// Last varlen byte position (four bytes at most)
	localparam logic [1:0] VARLEN_LAST = 2'd3;
	// Last tempo byte position (three bytes)
	localparam logic [1:0] TEMPO_LAST  = 2'd2;

	typedef enum logic [3:0] {
		PH_DELTA,
		PH_STATUS,
		PH_META_TYPE,
		PH_META_LEN,
		PH_SYX_LEN,
		PH_SKIP,
		PH_TEMPO,
		PH_DATA1,
		PH_DATA2A,
		PH_DATA2B
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic [27:0] vl_acc;
		logic [1:0]  vl_count;
		logic [31:0] abs_tick;
		logic [7:0]  running_status;
		logic [7:0]  meta_type;
		logic [27:0] skip_remaining;
		logic [1:0]  data_index;
		logic [23:0] tempo_capture;
		logic [23:0] tempo_value;
		logic        tempo_flag;
		logic [31:0] track_max;
		logic        closed;
		logic [2:0]  err_kind;
	} state_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       track_start;
		logic       track_last;
		logic       file_start;
	} item_t;

	typedef struct packed {
		logic        track_done;
		logic        track_error;
		logic [2:0]  error_kind;
		logic [31:0] max_note_tick;
		logic [23:0] tempo_us;
		logic        tempo_seen;
	} result_t;

endpackage

// ===== hw/rtl/midi_track_event_parser.sv =====
// MIDI track event parser: usage
// Input stream s_*: one track chunk byte per item. s_tdata[7:0] is the byte,
// s_tlast marks the last byte of the chunk, s_tuser[0] the first byte of a
// chunk (track restart) and s_tuser[1] the first byte of a file (tempo
// restored to the default). Output stream m_*: one result item per input
// item with the track status, latest note-on tick and current tempo.
// Configuration: cfg_valid/cfg_data load the default tempo; always ready.
// Write it only while the block is idle.
// Path: an accepted item waits in the input register; its result is then
// registered on m_*. Throughput: one item per cycle while m_tready is high;
// the parse of a byte is one pass of logic from the input register to the
// result register, the parser state updating as the result is registered.
// Stall: while m_tready is low the result holds and one more item can sit
// in the input register; s_tready drops only when both are full.
// Reset: arst_n clears both stages, the parser state to "expecting delta
// time" and the default and current tempo to 500000.
// Depends on mtep_pkg and mtep_parse.
module midi_track_event_parser import mtep_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [23:0] cfg_data,   // default_tempo
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] data_byte
	input  logic        s_tlast,    // track_last
	input  logic [1:0]  s_tuser,    // [0] track_start, [1] file_start
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata     // [0] track_done, [1] track_error,
	                                // [4:2] error_kind, [36:5] max_note_tick,
	                                // [60:37] tempo_us, [61] tempo_seen, zero
);

	logic        valid_s1;
	item_t       item_s1;
	logic        valid_s2;
	result_t     res_s2;
	state_t      state_q;
	logic [23:0] default_tempo_q;
	state_t      state_nxt;
	result_t     res_nxt;
	logic        adv;
	state_t      state_init;

	assign cfg_ready = 1'b1;

	// Stage 1 item moves on when the result register is free or draining
	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			default_tempo_q <= TEMPO_RESET;
		else if (cfg_valid && cfg_ready)
			default_tempo_q <= cfg_data;
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.data_byte   <= s_tdata;
			item_s1.track_start <= s_tuser[0];
			item_s1.track_last  <= s_tlast;
			item_s1.file_start  <= s_tuser[1];
		end
	end

	mtep_parse u_parse (
		.cur           (state_q),
		.item          (item_s1),
		.default_tempo (default_tempo_q),
		.nxt           (state_nxt),
		.res           (res_nxt)
	);

	// Reset value of the parser state
	always_comb begin
		state_init             = '0;
		state_init.phase       = PH_DELTA;
		state_init.tempo_value = TEMPO_RESET;
		state_init.err_kind    = ERR_NONE;
	end

	// Parser state updates as each item is committed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= state_init;
		else if (adv)
			state_q <= state_nxt;
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (adv)
			valid_s2 <= 1'b1;
		else if (m_tready)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_s2 <= res_nxt;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00, res_s2.tempo_seen, res_s2.tempo_us, res_s2.max_note_tick,
		res_s2.error_kind, res_s2.track_error, res_s2.track_done};

`ifndef ASSERT_OFF
	// a closed track stays closed until a track restart
	a_closed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && state_q.closed && !item_s1.track_start) |=> state_q.closed)
		else $error("closed track reopened without track start");

	// error kind and error flag agree in the result register
	a_err_kind: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ((res_s2.error_kind != ERR_NONE) == res_s2.track_error))
		else $error("error kind and error flag disagree");

	// a committed item always shows up as a result next cycle
	a_commit_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s2)
		else $error("committed item produced no result");

	// the parser state only changes when an item is committed
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(state_q))
		else $error("parser state changed without an item");
`endif

endmodule

// ===== hw/rtl/mtep_parse.sv =====
// Combinational next-state and result logic for one track byte.
// Depends on mtep_pkg.
module mtep_parse import mtep_pkg::*; (
	input  state_t      cur,
	input  item_t       item,
	input  logic [23:0] default_tempo,
	output state_t      nxt,
	output result_t     res
);

	state_t      w;
	state_t      n;
	logic [7:0]  b;
	logic [27:0] vl_val;
	logic        vl_end;
	logic        vl_long;
	logic [1:0]  vl_count_nxt;
	logic [3:0]  rs_kind;
	logic [3:0]  b_kind;
	logic [27:0] skip_dec;

	assign b = item.data_byte;

	// File and track restarts act before the byte is parsed
	always_comb begin
		w = cur;
		if (item.file_start) begin
			w.tempo_value = default_tempo;
			w.tempo_flag  = 1'b0;
		end
		if (item.track_start) begin
			w.phase          = PH_DELTA;
			w.vl_acc         = '0;
			w.vl_count       = '0;
			w.abs_tick       = '0;
			w.running_status = '0;
			w.meta_type      = '0;
			w.skip_remaining = '0;
			w.data_index     = '0;
			w.tempo_capture  = '0;
			w.track_max      = '0;
			w.closed         = 1'b0;
			w.err_kind       = ERR_NONE;
		end
	end

	// Varlen byte feed: seven bits a byte, four bytes at most
	assign vl_val       = (w.vl_count == 2'd0) ? {21'd0, b[6:0]} : {w.vl_acc[20:0], b[6:0]};
	assign vl_end       = !b[7];
	assign vl_long      = b[7] && (w.vl_count == VARLEN_LAST);
	assign vl_count_nxt = (vl_end || vl_long) ? 2'd0 : w.vl_count + 2'd1;
	assign rs_kind      = w.running_status[7:4];
	assign b_kind       = b[7:4];
	assign skip_dec     = (w.skip_remaining != 28'd0) ? w.skip_remaining - 28'd1 : 28'd0;

	// Byte parse by phase, then the chunk-end check
	always_comb begin
		n = w;
		if (!w.closed) begin
			case (w.phase)
				PH_STATUS: begin
					if (b[7]) begin
						if (b == STATUS_META) begin
							n.running_status = '0;
							n.phase          = PH_META_TYPE;
						end else if (b == STATUS_SYSEX || b == STATUS_ESCAPE) begin
							n.running_status = '0;
							n.meta_type      = '0;
							n.vl_count       = '0;
							n.phase          = PH_SYX_LEN;
						end else if (b_kind == KIND_SYSTEM) begin
							n.closed   = 1'b1;
							n.err_kind = ERR_UNSUPPORTED;
						end else begin
							n.running_status = b;
							n.phase = (b_kind == KIND_PROGRAM || b_kind == KIND_PRESSURE) ?
								PH_DATA1 : PH_DATA2A;
						end
					end else if (w.running_status == 8'd0) begin
						n.closed   = 1'b1;
						n.err_kind = ERR_NO_STATUS;
					end else begin
						n.phase = (rs_kind == KIND_PROGRAM || rs_kind == KIND_PRESSURE) ?
							PH_DELTA : PH_DATA2B;
					end
				end
				PH_DATA1: n.phase = PH_DELTA;
				PH_DATA2A: n.phase = PH_DATA2B;
				PH_DATA2B: begin
					// note-on with nonzero velocity moves the track maximum
					if (rs_kind == KIND_NOTE_ON && b != 8'd0 && w.abs_tick > w.track_max)
						n.track_max = w.abs_tick;
					n.phase = PH_DELTA;
				end
				PH_META_TYPE: begin
					n.meta_type = b;
					n.vl_count  = '0;
					n.phase     = PH_META_LEN;
				end
				PH_META_LEN: begin
					n.vl_acc   = vl_val;
					n.vl_count = vl_count_nxt;
					if (vl_long) begin
						n.closed   = 1'b1;
						n.err_kind = ERR_VARLEN;
					end else if (vl_end) begin
						if (w.meta_type == META_EOT && vl_val == 28'd0) begin
							n.closed   = 1'b1;
							n.err_kind = ERR_NONE;
						end else if (w.meta_type == META_TEMPO && vl_val == 28'd3) begin
							n.data_index    = '0;
							n.tempo_capture = '0;
							n.phase         = PH_TEMPO;
						end else if (vl_val == 28'd0) begin
							n.phase = PH_DELTA;
						end else begin
							n.skip_remaining = vl_val;
							n.phase          = PH_SKIP;
						end
					end
				end
				PH_SYX_LEN: begin
					n.vl_acc   = vl_val;
					n.vl_count = vl_count_nxt;
					if (vl_long) begin
						n.closed   = 1'b1;
						n.err_kind = ERR_VARLEN;
					end else if (vl_end) begin
						if (vl_val == 28'd0) begin
							n.phase = PH_DELTA;
						end else begin
							n.skip_remaining = vl_val;
							n.phase          = PH_SKIP;
						end
					end
				end
				PH_SKIP: begin
					n.skip_remaining = skip_dec;
					if (skip_dec == 28'd0) begin
						if (w.meta_type == META_EOT) begin
							n.closed   = 1'b1;
							n.err_kind = ERR_NONE;
						end else begin
							n.phase = PH_DELTA;
						end
					end
				end
				PH_TEMPO: begin
					n.tempo_capture = {w.tempo_capture[15:0], b};
					n.data_index    = w.data_index + 2'd1;
					if (w.data_index == TEMPO_LAST) begin
						n.tempo_value = {w.tempo_capture[15:0], b};
						n.tempo_flag  = 1'b1;
						n.data_index  = '0;
						n.phase       = PH_DELTA;
					end
				end
				default: begin
					// delta time, also any unused phase code
					n.phase    = PH_DELTA;
					n.vl_acc   = vl_val;
					n.vl_count = vl_count_nxt;
					if (vl_long) begin
						n.closed   = 1'b1;
						n.err_kind = ERR_VARLEN;
					end else if (vl_end) begin
						n.abs_tick = w.abs_tick + {4'd0, vl_val};
						n.phase    = PH_STATUS;
					end
				end
			endcase
			// chunk end: clean only between events
			if (!n.closed && item.track_last) begin
				n.closed   = 1'b1;
				n.err_kind = (n.phase == PH_DELTA && n.vl_count == 2'd0) ?
					ERR_NONE : ERR_TRUNCATED;
			end
		end
	end

	assign nxt = n;

	// Result fields from the updated state
	always_comb begin
		res.track_done    = n.closed && (n.err_kind == ERR_NONE);
		res.track_error   = n.closed && (n.err_kind != ERR_NONE);
		res.error_kind    = n.closed ? n.err_kind : ERR_NONE;
		res.max_note_tick = n.track_max;
		res.tempo_us      = n.tempo_value;
		res.tempo_seen    = n.tempo_flag;
	end

endmodule
